FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
// every use expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cfh_pkg.sv
package cfh_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned BUCKET_W = 16;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [31:0] POS_START = 32'h0000_0100;
    localparam logic [31:0] POS_STEP  = 32'h0000_0100;
    localparam logic [COUNT_W-1:0] MAX_BUCKETS   = 17'h1_0000;
    localparam logic [COUNT_W-1:0] RESET_BUCKETS = 17'd256;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTEGER_KEY_MODE = 2'd0,
        REG_WIDE_CHAR_MODE   = 2'd1,
        REG_BUCKET_COUNT     = 2'd2
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_DIV,
        ST_EMIT
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic                start;
        logic [KEY_W-1:0]    dividend;
        logic [COUNT_W-1:0]  divisor;
    } div_cmd_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [BUCKET_W-1:0] remainder;
    } div_sts_t;

endpackage

FILE: rtl/cfh_key_if.sv
interface cfh_key_if
    import cfh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_data;

    modport source (output valid, output key_data, input ready);
    modport sink   (input valid, input key_data, output ready);
endinterface

FILE: rtl/cfh_res_if.sv
interface cfh_res_if
    import cfh_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket_index;
    logic [KEY_W-1:0]    folded_hash;

    modport source (output valid, output bucket_index, output folded_hash, input ready);
    modport sink   (input valid, input bucket_index, input folded_hash, output ready);
endinterface

FILE: rtl/cfh_cfg_if.sv
interface cfh_cfg_if
    import cfh_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/case_folding_string_bucket_hash_core.sv
// character word: accepted, hashed in the following cycle, next word taken once the hash state returns to idle
// key end or integer key: radix-2 restoring divider for the bucket modulo, result word
// registered from the emit state, which waits while an untaken result is held; next word
// taken back in idle; the output register decouples the result from input; one key word in flight at a time
// reset: mode bits 0, bucket count 256, running hash 0, position word 0x100
`include "assert_macros.svh"

module case_folding_string_bucket_hash_core
    import cfh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cfh_key_if.sink   key_in,
    cfh_res_if.source res_out,
    cfh_cfg_if.sink   cfg
);

    state_t state_reg, state_next;

    logic               int_mode_reg, int_mode_next;
    logic               wide_mode_reg, wide_mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0]   hash_reg, hash_next;
    logic [KEY_W-1:0]   pos_reg, pos_next;
    logic [KEY_W-1:0]   v_reg, v_next;
    logic [KEY_W-1:0]   fold_reg, fold_next;
    logic               out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0] out_bucket_reg, out_bucket_next;
    logic [KEY_W-1:0]   out_fold_reg, out_fold_next;

    logic               key_acc;
    logic [KEY_W-1:0]   ch_raw;
    logic [KEY_W-1:0]   ch_low;
    logic [KEY_W-1:0]   fold_str;
    logic [COUNT_W-1:0] eff_count;
    logic [3:0]         rot;
    logic [2*KEY_W-1:0] rot_wide;
    logic [KEY_W-1:0]   square;
    div_cmd_t           div_cmd;
    div_sts_t           div_sts;

    cfh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .sts   (div_sts)
    );

    assign key_in.ready = (state_reg == ST_IDLE);
    assign key_acc      = key_in.valid && key_in.ready;
    assign cfg.ready    = 1'b1;

    // configuration writes
    always_comb
    begin
        int_mode_next  = int_mode_reg;
        wide_mode_next = wide_mode_reg;
        count_next     = count_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_INTEGER_KEY_MODE: int_mode_next  = cfg.data[0];
                REG_WIDE_CHAR_MODE:   wide_mode_next = cfg.data[0];
                REG_BUCKET_COUNT:     count_next     = cfg.data;
                default: ;
            endcase
        end
    end

    // effective bucket count, zero taken as one and clamped to the maximum
    always_comb
    begin
        if (count_reg == '0)
            eff_count = COUNT_W'(1);
        else if (count_reg > MAX_BUCKETS)
            eff_count = MAX_BUCKETS;
        else
            eff_count = count_reg;
    end

    // character extraction, sign extension of narrow or zero extension of wide characters, lower-case fold
    always_comb
    begin
        if (wide_mode_reg)
            ch_raw = {16'h0000, key_in.key_data[15:0]};
        else
            ch_raw = {{24{key_in.key_data[7]}}, key_in.key_data[7:0]};
        if (ch_raw >= 32'h41 && ch_raw <= 32'h5A)
            ch_low = ch_raw + 32'h20;
        else
            ch_low = ch_raw;
    end

    assign fold_str = {16'h0000, hash_reg[31:16]} ^ hash_reg;

    // rotate and square for the hash update
    assign rot      = v_reg[5:2] ^ v_reg[3:0];
    assign rot_wide = {hash_reg, hash_reg} << rot;
    assign square   = KEY_W'(v_reg * v_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        hash_next       = hash_reg;
        pos_next        = pos_reg;
        v_next          = v_reg;
        fold_next       = fold_reg;
        out_valid_next  = out_valid_reg;
        out_bucket_next = out_bucket_reg;
        out_fold_next   = out_fold_reg;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = key_in.key_data;
        div_cmd.divisor  = eff_count;

        if (out_valid_reg && res_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (key_acc)
                begin
                    if (int_mode_reg)
                    begin
                        fold_next     = key_in.key_data;
                        div_cmd.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else if (ch_raw == '0)
                    begin
                        fold_next        = fold_str;
                        div_cmd.dividend = fold_str;
                        div_cmd.start    = 1'b1;
                        hash_next        = '0;
                        pos_next         = POS_START;
                        state_next       = ST_DIV;
                    end
                    else
                    begin
                        v_next     = pos_reg | ch_low;
                        pos_next   = pos_reg + POS_STEP;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                hash_next  = rot_wide[2*KEY_W-1:KEY_W] ^ square;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_sts.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_bucket_next = div_sts.remainder;
                    out_fold_next   = fold_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            int_mode_reg  <= 1'b0;
            wide_mode_reg <= 1'b0;
            count_reg     <= RESET_BUCKETS;
            hash_reg      <= '0;
            pos_reg       <= POS_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            int_mode_reg  <= int_mode_next;
            wide_mode_reg <= wide_mode_next;
            count_reg     <= count_next;
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg          <= v_next;
        fold_reg       <= fold_next;
        out_bucket_reg <= out_bucket_next;
        out_fold_reg   <= out_fold_next;
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.bucket_index = out_bucket_reg;
    assign res_out.folded_hash  = out_fold_reg;

    `CFH_ASSERT_NXT(a_hash_one_cycle, state_reg == ST_HASH, state_reg == ST_IDLE, "hash step overran")
    `CFH_ASSERT_IMP(a_done_in_div, div_sts.done, state_reg == ST_DIV, "divider done outside div state")
    `CFH_ASSERT_IMP(a_div_running, state_reg == ST_DIV && !div_sts.done, div_sts.busy, "divider idle while waited on")
    `CFH_ASSERT_NXT(a_emit_valid, state_reg == ST_EMIT && state_next == ST_IDLE, out_valid_reg, "result word lost")

endmodule

FILE: rtl/cfh_div.sv
`include "assert_macros.svh"

module cfh_div
    import cfh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_sts_t sts
);

    localparam int unsigned CNT_W = $clog2(KEY_W) + 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_W-1:0]    dvd_reg, dvd_next;
    logic [COUNT_W-1:0]  dsr_reg, dsr_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W:0]    trial;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    // one restoring step per cycle, msb first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[KEY_W-1]};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = cmd.dividend;
            dsr_next  = cmd.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.busy      = busy_reg;
    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg[BUCKET_W-1:0];

    `CFH_ASSERT_IMP(a_rem_below_divisor, done_reg, rem_reg < dsr_reg, "remainder not below divisor")
    `CFH_ASSERT_IMP(a_no_restart_busy, cmd.start, !busy_reg, "divider started while busy")

endmodule
